// ===== rtl/core/dhv_pkg.sv =====
// Shared types, codes and the payload type table of the DoIP header validator.
package dhv_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned CountW      = $clog2(HeaderBytes) + 1;
  localparam int unsigned IdxW        = $clog2(HeaderBytes);

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam logic [7:0] VER_SUM = 8'hFF;

  localparam logic [15:0] PT_NACK         = 16'h0000;
  localparam logic [15:0] PT_VID_REQ      = 16'h0001;
  localparam logic [15:0] PT_VID_REQ_EID  = 16'h0002;
  localparam logic [15:0] PT_VID_REQ_VIN  = 16'h0003;
  localparam logic [15:0] PT_VID_RSP      = 16'h0004;
  localparam logic [15:0] PT_ROUTE_REQ    = 16'h0005;
  localparam logic [15:0] PT_ROUTE_RSP    = 16'h0006;
  localparam logic [15:0] PT_ALIVE_REQ    = 16'h0007;
  localparam logic [15:0] PT_ALIVE_RSP    = 16'h0008;
  localparam logic [15:0] PT_ENT_REQ      = 16'h4001;
  localparam logic [15:0] PT_ENT_RSP      = 16'h4002;
  localparam logic [15:0] PT_PWR_REQ      = 16'h4003;
  localparam logic [15:0] PT_PWR_RSP      = 16'h4004;
  localparam logic [15:0] PT_DIAG_MSG     = 16'h8001;
  localparam logic [15:0] PT_DIAG_ACK     = 16'h8002;
  localparam logic [15:0] PT_DIAG_NACK    = 16'h8003;

  typedef struct packed {
    logic        short_pkt;
    logic        is_tcp;
    logic [7:0]  ver;
    logic [7:0]  inv_ver;
    logic [15:0] ptype;
    logic [31:0] plen;
    logic [31:0] seen;
  } dhv_rec_t;

  function automatic logic type_ok(input logic [15:0] ptype, input logic [31:0] plen,
                                   input logic tcp);
    logic ok;
    begin
      case (ptype)
        PT_NACK:        ok = (plen == 32'd1);
        PT_VID_REQ:     ok = (plen == 32'd0) && !tcp;
        PT_VID_REQ_EID: ok = (plen == 32'd6) && !tcp;
        PT_VID_REQ_VIN: ok = (plen == 32'd17) && !tcp;
        PT_VID_RSP:     ok = ((plen == 32'd32) || (plen == 32'd33)) && !tcp;
        PT_ROUTE_REQ:   ok = ((plen == 32'd7) || (plen == 32'd11)) && tcp;
        PT_ROUTE_RSP:   ok = ((plen == 32'd9) || (plen == 32'd13)) && tcp;
        PT_ALIVE_REQ:   ok = (plen == 32'd0) && tcp;
        PT_ALIVE_RSP:   ok = (plen == 32'd2) && tcp;
        PT_ENT_REQ:     ok = (plen == 32'd0) && !tcp;
        PT_ENT_RSP:     ok = (plen == 32'd7) && !tcp;
        PT_PWR_REQ:     ok = (plen == 32'd0) && !tcp;
        PT_PWR_RSP:     ok = (plen == 32'd1) && !tcp;
        PT_DIAG_MSG,
        PT_DIAG_ACK,
        PT_DIAG_NACK:   ok = (plen >= 32'd5) && tcp;
        default:        ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

endpackage

// ===== rtl/core/dhv_if.sv =====
// Byte input and verdict output channel interfaces of the DoIP header validator.
interface dhv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_tcp;
  logic       last;

  modport source (output valid, output data_byte, output is_tcp, output last, input ready);
  modport sink (input valid, input data_byte, input is_tcp, input last, output ready);
endinterface

interface dhv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] payload_type;
  logic [31:0] payload_length;
  logic [7:0]  protocol_version;

  modport source (output valid, output status, output payload_type, output payload_length,
                  output protocol_version, input ready);
  modport sink (input valid, input status, input payload_type, input payload_length,
                input protocol_version, output ready);
endinterface

// ===== rtl/core/dhv_collect.sv =====
// Header gathering, payload counting and packet record register.
module dhv_collect (
  input  logic              clk_i,
  input  logic              rst_ni,
  dhv_in_if.sink            in_i,
  output logic              rec_vld_o,
  input  logic              rec_rdy_i,
  output dhv_pkg::dhv_rec_t rec_o
);
  import dhv_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_nxt;
  logic [31:0]       seen_q, seen_d, seen_nxt;
  logic [7:0]        hdr_q [HeaderBytes];
  logic [7:0]        hdr_d [HeaderBytes];
  logic              hdr_full;
  logic              accept;
  logic              rec_vld_q, rec_vld_d;
  dhv_rec_t          rec_q, rec_d;

  assign hdr_full  = (cnt_q == CountW'(HeaderBytes));
  assign in_i.ready = !rec_vld_q || rec_rdy_i;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    hdr_d    = hdr_q;
    cnt_nxt  = cnt_q;
    seen_nxt = seen_q;
    if (!hdr_full) begin
      hdr_d[cnt_q[IdxW-1:0]] = in_i.data_byte;
      cnt_nxt = cnt_q + CountW'(1);
    end else if (seen_q != '1) begin
      seen_nxt = seen_q + 32'd1;
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    rec_vld_d = rec_vld_q && !rec_rdy_i;
    if (accept) begin
      if (in_i.last) begin
        cnt_d     = '0;
        seen_d    = '0;
        rec_vld_d = 1'b1;
      end else begin
        cnt_d  = cnt_nxt;
        seen_d = seen_nxt;
      end
    end
  end

  always_comb begin
    rec_d.short_pkt = (cnt_nxt != CountW'(HeaderBytes));
    rec_d.is_tcp    = in_i.is_tcp;
    rec_d.ver       = hdr_d[0];
    rec_d.inv_ver   = hdr_d[1];
    rec_d.ptype     = {hdr_d[2], hdr_d[3]};
    rec_d.plen      = {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
    rec_d.seen      = seen_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      seen_q    <= '0;
      rec_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      rec_vld_q <= rec_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q <= hdr_d;
    end
    if (accept && in_i.last) begin
      rec_q <= rec_d;
    end
  end

  assign rec_vld_o = rec_vld_q;
  assign rec_o     = rec_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(HeaderBytes))
    else $error("header count out of range");

  a_seen_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != '0) |-> hdr_full)
    else $error("payload counted before header complete");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last) |=> (cnt_q == '0) && (seen_q == '0) && rec_vld_q)
    else $error("last byte did not restart the packet");
`endif

endmodule

// ===== rtl/core/dhv_check.sv =====
// Version, type table and completeness checks with the verdict output register.
module dhv_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_vld_i,
  output logic              rec_rdy_o,
  input  dhv_pkg::dhv_rec_t rec_i,
  dhv_out_if.source         out_o
);
  import dhv_pkg::*;

  logic        out_vld_q, out_vld_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] ptype_q, ptype_d;
  logic [31:0] plen_q, plen_d;
  logic [7:0]  ver_q, ver_d;
  logic        ver_bad;
  logic        take;

  assign rec_rdy_o = !out_vld_q || out_o.ready;
  assign take      = rec_vld_i && rec_rdy_o;
  assign ver_bad   = ({1'b0, rec_i.ver} + {1'b0, rec_i.inv_ver}) != {1'b0, VER_SUM};

  always_comb begin
    ptype_d = rec_i.ptype;
    plen_d  = rec_i.plen;
    ver_d   = rec_i.ver;
    if (rec_i.short_pkt) begin
      status_d = ST_BAD_FORMAT;
      ptype_d  = '0;
      plen_d   = '0;
      ver_d    = '0;
    end else if (ver_bad) begin
      status_d = ST_BAD_FORMAT;
    end else if (!type_ok(rec_i.ptype, rec_i.plen, rec_i.is_tcp)) begin
      status_d = ST_BAD_TYPE;
    end else if (rec_i.seen < rec_i.plen) begin
      status_d = ST_INCOMPLETE;
    end else begin
      status_d = ST_OK;
    end
  end

  assign out_vld_d = take || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      ptype_q  <= ptype_d;
      plen_q   <= plen_d;
      ver_q    <= ver_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.status           = status_q;
  assign out_o.payload_type     = ptype_q;
  assign out_o.payload_length   = plen_q;
  assign out_o.protocol_version = ver_q;

`ifndef SYNTH
  a_short_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rec_i.short_pkt) |=> out_vld_q && (status_q == ST_BAD_FORMAT)
      && (ptype_q == '0) && (plen_q == '0) && (ver_q == '0))
    else $error("short packet verdict wrong");

  a_version_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !rec_i.short_pkt && ver_bad) |=> (status_q == ST_BAD_FORMAT))
    else $error("version mismatch not reported");

  a_ok_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (status_d == ST_OK)) |-> (rec_i.seen >= rec_i.plen) && !ver_bad)
    else $error("ok verdict on incomplete or bad packet");
`endif

endmodule

// ===== rtl/core/doip_header_validator_unit.sv =====
// Top level of the DoIP generic header validator.
// After the last byte of a packet is accepted, the record register and then the verdict register are loaded.
// Throughput: one byte per cycle while the input is not stalled; a packet may start in the cycle after a last byte.
// The record register and the verdict register decouple input from a stalled output.
// Reset clears the header count, the payload count and both valid flags.
// Header byte storage is not reset; stale bytes of a short packet do not reach the verdict, which zeroes its fields.
module doip_header_validator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhv_in_if.sink    in_i,
  dhv_out_if.source out_o
);
  import dhv_pkg::*;

  logic     rec_vld;
  logic     rec_rdy;
  dhv_rec_t rec;

  dhv_collect u_collect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .rec_vld_o (rec_vld),
    .rec_rdy_i (rec_rdy),
    .rec_o     (rec)
  );

  dhv_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_vld_i (rec_vld),
    .rec_rdy_o (rec_rdy),
    .rec_i     (rec),
    .out_o     (out_o)
  );

endmodule
